// ===== design/shell_word_splitter_top_assert.svh =====
// Assertion macros shared by the shell word splitter RTL.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef SHELL_WORD_SPLITTER_TOP_ASSERT_SVH
`define SHELL_WORD_SPLITTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SWS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: %m");

`define SWS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

`define SWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`else

`define SWS_ASSERT_ALWAYS(label, clk, rst, cond)
`define SWS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SWS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/sws_pkg.sv =====
// Types and constants of the shell word splitter.
// No dependencies; used by sws_decode, sws_result_queue and the top level.
`timescale 1ns / 1ps

package sws_pkg;

   localparam logic [2:0] MODE_NONE       = 3'd0;
   localparam logic [2:0] MODE_SINGLE     = 3'd1;
   localparam logic [2:0] MODE_DOUBLE     = 3'd2;
   localparam logic [2:0] MODE_ESC_NONE   = 3'd3;
   localparam logic [2:0] MODE_ESC_DOUBLE = 3'd4;

   localparam logic [2:0] KIND_BYTE      = 3'd0;
   localparam logic [2:0] KIND_WORD_END  = 3'd1;
   localparam logic [2:0] KIND_DONE      = 3'd2;
   localparam logic [2:0] KIND_QUOTE_ERR = 3'd3;
   localparam logic [2:0] KIND_ESC_ERR   = 3'd4;

   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_FORMFEED  = 8'h0C;
   localparam logic [7:0] CHAR_VTAB      = 8'h0B;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_text;
   } request_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0]            count;
      result_type [1:0]      res;
   } push_type;

   typedef struct packed {
      push_type   push;
      logic [2:0] mode_next;
      logic       word_open_next;
   } decode_type;

endpackage

// ===== design/sws_channel_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
// Depends on nothing; payload types come from sws_pkg.
`timescale 1ns / 1ps

interface sws_channel_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sws_decode.sv =====
// Next-state and result decode for one request of the word splitter.
// Depends on sws_pkg.
`timescale 1ns / 1ps

module sws_decode (
   input  logic [2:0]          mode,
   input  logic                word_open,
   input  sws_pkg::request_type req,
   output sws_pkg::decode_type  dec
);

   logic                 is_ws;
   sws_pkg::result_type  byte_res;
   sws_pkg::result_type  bs_res;

   always_comb begin
      is_ws = (req.char_byte == sws_pkg::CHAR_SPACE)   ||
              (req.char_byte == sws_pkg::CHAR_TAB)     ||
              (req.char_byte == sws_pkg::CHAR_NEWLINE) ||
              (req.char_byte == sws_pkg::CHAR_RETURN)  ||
              (req.char_byte == sws_pkg::CHAR_FORMFEED) ||
              (req.char_byte == sws_pkg::CHAR_VTAB);

      byte_res.kind        = sws_pkg::KIND_BYTE;
      byte_res.out_byte    = req.char_byte;
      byte_res.last_of_run = 1'b1;

      bs_res.kind        = sws_pkg::KIND_BYTE;
      bs_res.out_byte    = sws_pkg::CHAR_BACKSLASH;
      bs_res.last_of_run = 1'b0;

      dec.push.count          = 2'd0;
      dec.push.res[0]         = byte_res;
      dec.push.res[1]         = byte_res;
      dec.mode_next           = mode;
      dec.word_open_next      = word_open;

      if (req.end_of_text) begin
         dec.mode_next      = sws_pkg::MODE_NONE;
         dec.word_open_next = 1'b0;
         dec.push.res[0].out_byte = 8'd0;
         dec.push.res[1].out_byte = 8'd0;
         dec.push.res[1].kind     = sws_pkg::KIND_DONE;
         priority if (mode == sws_pkg::MODE_SINGLE || mode == sws_pkg::MODE_DOUBLE ||
                      mode == sws_pkg::MODE_ESC_DOUBLE) begin
            dec.push.count       = 2'd1;
            dec.push.res[0].kind = sws_pkg::KIND_QUOTE_ERR;
         end else if (mode == sws_pkg::MODE_ESC_NONE) begin
            dec.push.count       = 2'd1;
            dec.push.res[0].kind = sws_pkg::KIND_ESC_ERR;
         end else if (word_open) begin
            dec.push.count                  = 2'd2;
            dec.push.res[0].kind            = sws_pkg::KIND_WORD_END;
            dec.push.res[0].last_of_run     = 1'b0;
         end else begin
            dec.push.count       = 2'd1;
            dec.push.res[0].kind = sws_pkg::KIND_DONE;
         end
      end else begin
         unique case (mode)
            sws_pkg::MODE_SINGLE: begin
               if (req.char_byte == sws_pkg::CHAR_SQUOTE) begin
                  dec.mode_next = sws_pkg::MODE_NONE;
               end else begin
                  dec.push.count = 2'd1;
               end
            end
            sws_pkg::MODE_DOUBLE: begin
               priority if (req.char_byte == sws_pkg::CHAR_DQUOTE) begin
                  dec.mode_next = sws_pkg::MODE_NONE;
               end else if (req.char_byte == sws_pkg::CHAR_BACKSLASH) begin
                  dec.mode_next = sws_pkg::MODE_ESC_DOUBLE;
               end else begin
                  dec.push.count = 2'd1;
               end
            end
            sws_pkg::MODE_ESC_DOUBLE: begin
               dec.mode_next = sws_pkg::MODE_DOUBLE;
               if (req.char_byte != sws_pkg::CHAR_BACKSLASH &&
                   req.char_byte != sws_pkg::CHAR_DQUOTE) begin
                  dec.push.count  = 2'd2;
                  dec.push.res[0] = bs_res;
               end else begin
                  dec.push.count = 2'd1;
               end
            end
            sws_pkg::MODE_ESC_NONE: begin
               dec.mode_next      = sws_pkg::MODE_NONE;
               dec.word_open_next = 1'b1;
               dec.push.count     = 2'd1;
            end
            default: begin
               dec.mode_next = sws_pkg::MODE_NONE;
               priority if (is_ws) begin
                  if (word_open) begin
                     dec.push.count              = 2'd1;
                     dec.push.res[0].kind        = sws_pkg::KIND_WORD_END;
                     dec.push.res[0].out_byte    = 8'd0;
                     dec.word_open_next          = 1'b0;
                  end
               end else if (req.char_byte == sws_pkg::CHAR_SQUOTE) begin
                  dec.mode_next      = sws_pkg::MODE_SINGLE;
                  dec.word_open_next = 1'b1;
               end else if (req.char_byte == sws_pkg::CHAR_DQUOTE) begin
                  dec.mode_next      = sws_pkg::MODE_DOUBLE;
                  dec.word_open_next = 1'b1;
               end else if (req.char_byte == sws_pkg::CHAR_BACKSLASH) begin
                  dec.mode_next = sws_pkg::MODE_ESC_NONE;
               end else begin
                  dec.push.count     = 2'd1;
                  dec.word_open_next = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

// ===== design/sws_result_queue.sv =====
// Four-entry result queue: takes up to two results a cycle while it has room, gives one.
// Depends on sws_pkg and shell_word_splitter_top_assert.svh.
`timescale 1ns / 1ps

`include "shell_word_splitter_top_assert.svh"

module sws_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  sws_pkg::push_type    push,
   input  logic                pop,
   output logic                has_room,
   output logic                out_valid,
   output sws_pkg::result_type  out_res
);

   localparam int unsigned PTR_W = $clog2(sws_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = PTR_W + 1;

   sws_pkg::result_type entries_ff [sws_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    head_ff;
   logic [PTR_W-1:0]    head_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [PTR_W-1:0]    tail0;
   logic [PTR_W-1:0]    tail1;

   always_comb begin
      tail0    = head_ff + count_ff[PTR_W-1:0];
      tail1    = tail0 + PTR_W'(1);
      head_in  = head_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   assign has_room  = (count_ff <= CNT_W'(sws_pkg::QUEUE_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_res   = entries_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[tail0] <= push.res[0];
      end
      if (push.count == 2'd2) begin
         entries_ff[tail1] <= push.res[1];
      end
   end

   `SWS_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= CNT_W'(sws_pkg::QUEUE_DEPTH))
   `SWS_ASSERT_IMPLIES(a_push_fits, clock, reset, push.count != 2'd0, has_room)
   `SWS_ASSERT_IMPLIES(a_pop_nonempty, clock, reset, pop, out_valid)
   `SWS_ASSERT_NEXT(a_pop_only_drains, clock, reset, pop && push.count == 2'd0,
      count_ff == $past(count_ff) - CNT_W'(1))

endmodule

// ===== design/shell_word_splitter_top.sv =====
// Shell word splitter top level: POSIX-style word splitting of a byte stream.
// Depends on sws_pkg, sws_channel_if, sws_decode, sws_result_queue and
// shell_word_splitter_top_assert.svh.
//
// req_stream carries one text byte per request, or an end-of-text marker.
// rsp_stream carries results: word bytes, word-end marks and one status per
// text (done, unterminated quote, trailing escape); last_of_run flags the
// final result of each request. A request yields zero, one or two results.
// With the queue empty, the first result of a request appears on
// rsp_stream the cycle after it is taken; queued results ahead of it go first.
// The splitter takes one request per cycle while requests yield at most one
// result each and rsp_stream.ready stays high; the one-result-per-cycle output
// port sets the limit, so requests that yield two results let the queue fill.
// A four-entry result queue sits between decode and the output port;
// req_stream.ready depends only on its fill level, never on rsp_stream.ready.
// When the receiver stalls, the queue fills and ready drops once fewer than
// two entries are free. Reset (synchronous, active high) empties the queue
// and returns the quote mode and word state to outside quotes, no word open.
`timescale 1ns / 1ps

`include "shell_word_splitter_top_assert.svh"

module shell_word_splitter_top (
   input  logic          clock,
   input  logic          reset,
   sws_channel_if.sink   req_stream,
   sws_channel_if.source rsp_stream
);

   logic [2:0]           mode_ff;
   logic [2:0]           mode_in;
   logic                 word_open_ff;
   logic                 word_open_in;
   logic                 req_accept;
   logic                 has_room;
   sws_pkg::decode_type  dec;
   sws_pkg::push_type    push;
   sws_pkg::request_type req_data;

   assign req_data          = req_stream.payload;
   assign req_stream.ready  = has_room;
   assign req_accept        = req_stream.valid && has_room;

   sws_decode u_decode (
      .mode      (mode_ff),
      .word_open (word_open_ff),
      .req       (req_data),
      .dec       (dec)
   );

   always_comb begin
      push = dec.push;
      if (!req_accept) begin
         push.count = 2'd0;
      end
      mode_in      = req_accept ? dec.mode_next : mode_ff;
      word_open_in = req_accept ? dec.word_open_next : word_open_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= sws_pkg::MODE_NONE;
         word_open_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         word_open_ff <= word_open_in;
      end
   end

   sws_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_stream.valid && rsp_stream.ready),
      .has_room  (has_room),
      .out_valid (rsp_stream.valid),
      .out_res   (rsp_stream.payload)
   );

   `SWS_ASSERT_ALWAYS(a_mode_legal, clock, reset, mode_ff <= sws_pkg::MODE_ESC_DOUBLE)
   `SWS_ASSERT_NEXT(a_eot_clears, clock, reset, req_accept && req_data.end_of_text,
      mode_ff == sws_pkg::MODE_NONE && !word_open_ff)

endmodule
